// ----- design/jeof_pkg.sv -----
package jeof_pkg;

    localparam int unsigned SegmentBytesDefault = 65536;

    localparam logic [7:0] MarkerPrefix = 8'hFF;
    localparam logic [7:0] MarkerSoi    = 8'hD8;
    localparam logic [7:0] MarkerTem    = 8'h01;
    localparam logic [7:0] MarkerRst0   = 8'hD0;
    localparam logic [7:0] MarkerRst7   = 8'hD7;
    localparam logic [7:0] MarkerSos    = 8'hDA;
    localparam logic [7:0] MarkerEoi    = 8'hD9;
    localparam logic [7:0] MarkerApp1   = 8'hE1;

    localparam logic [15:0] TagOrientation = 16'h0112;
    localparam logic [15:0] TiffMagic      = 16'd42;
    localparam logic [15:0] OrderBig       = 16'h4D4D;
    localparam logic [15:0] OrderLittle    = 16'h4949;
    localparam logic [3:0]  OrientDefault  = 4'd1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RES,
        OP_LOOK
    } t_op;

    // One queue entry: an optional buffer write plus an optional action.
    typedef struct packed {
        logic        wr;
        t_op         op;
        logic [15:0] idx;
        logic [7:0]  data;
        logic [16:0] size;
    } t_cmd;

endpackage

// ----- design/jpeg_exif_orientation_finder_top.sv -----
// Throughput: one file byte per cycle while the command queue has room.
// A failure or end-of-file answer is queued; the back end registers it as the result
// once it is idle and no beat is waiting. The Exif lookup reads each TIFF byte via a
// fetch and a catch state: byte order, magic, IFD0 offset, entry tags and the value.
// The next file streams in during a lookup until the 4-entry queue fills.
// Reset (i_rst_n low, synchronous) returns parser and queue to the start of a file;
// the TIFF buffer is not cleared.
module jpeg_exif_orientation_finder_top #(
    parameter int unsigned SEGMENT_BYTES = jeof_pkg::SegmentBytesDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_orientation
);
    import jeof_pkg::*;

    // Front: walk markers, classify each byte into a buffer write or an action.
    logic q_full, q_push, q_valid, q_pop, out_busy;
    t_cmd f_cmd, q_cmd;

    jeof_front #(.SEGMENT_BYTES(SEGMENT_BYTES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_end_of_file(i_end_of_file),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (f_cmd)
    );

    // Queue: decouple byte intake from the multi-cycle lookup.
    jeof_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (f_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    // Back: fill the TIFF buffer, run the IFD0 scan, drive the result beat.
    jeof_back #(.SEGMENT_BYTES(SEGMENT_BYTES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (q_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_orientation(o_orientation)
    );

    // Hold intake only on a full queue; a waiting result beat does not block it.
    jeof_out_guard u_guard (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_busy (out_busy)
    );

    assign o_in_stall = q_full || (out_busy && 1'b0);

endmodule

// ----- design/jeof_front.sv -----
module jeof_front #(
    parameter int unsigned SEGMENT_BYTES = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_file,
    input  logic           i_full,
    output logic           o_push,
    output jeof_pkg::t_cmd o_cmd
);
    import jeof_pkg::*;

    localparam logic [16:0] SegLim = 17'(SEGMENT_BYTES);

    typedef enum logic [3:0] {
        PH_SOI_A, PH_SOI_B, PH_MARK_FF, PH_MARK_ID, PH_LEN_HI,
        PH_LEN_LO, PH_HEADER, PH_SKIP, PH_TIFF, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic        r_ans, n_ans;

    logic        accept, got;
    logic [15:0] full_len, held;
    logic [16:0] idx17, held17;
    logic [7:0]  head_byte;
    t_cmd        cmd;

    assign accept = i_valid && !i_full;

    always_comb begin
        case (r_pos)
            3'd0:    head_byte = 8'h45;
            3'd1:    head_byte = 8'h78;
            3'd2:    head_byte = 8'h69;
            3'd3:    head_byte = 8'h66;
            default: head_byte = 8'h00;
        endcase
    end

    assign full_len = {r_len[7:0], i_data_byte};
    assign held     = r_len - 16'd8;
    assign held17   = {1'b0, held};
    assign idx17    = held17 - {1'b0, r_cnt};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_marker = r_marker;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_ans    = r_ans;
        got      = 1'b0;
        cmd.wr   = 1'b0;
        cmd.op   = OP_NONE;
        cmd.idx  = idx17[15:0];
        cmd.data = i_data_byte;
        cmd.size = (held17 < SegLim) ? held17 : SegLim;
        case (r_phase)
            PH_SOI_A: begin
                if (i_data_byte == MarkerPrefix) n_phase = PH_SOI_B;
                else got = 1'b1;
            end
            PH_SOI_B: begin
                if (i_data_byte == MarkerSoi) n_phase = PH_MARK_FF;
                else got = 1'b1;
            end
            PH_MARK_FF: begin
                if (i_data_byte == MarkerPrefix) n_phase = PH_MARK_ID;
                else got = 1'b1;
            end
            PH_MARK_ID: begin
                n_marker = i_data_byte;
                if (i_data_byte == MarkerSoi || i_data_byte == MarkerTem
                    || (i_data_byte >= MarkerRst0 && i_data_byte <= MarkerRst7)) begin
                    n_phase = PH_MARK_FF;
                end else if (i_data_byte == MarkerSos || i_data_byte == MarkerEoi) begin
                    got = 1'b1;
                end else begin
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_len   = {8'h00, i_data_byte};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = full_len;
                if (full_len < 16'd2) begin
                    got = 1'b1;
                end else if (full_len == 16'd2) begin
                    n_phase = PH_MARK_FF;
                end else begin
                    n_cnt   = full_len - 16'd2;
                    n_pos   = 3'd0;
                    n_phase = (r_marker == MarkerApp1 && full_len > 16'd16)
                              ? PH_HEADER : PH_SKIP;
                end
            end
            PH_HEADER: begin
                n_cnt = r_cnt - 16'd1;
                if (i_data_byte == head_byte) begin
                    n_pos = r_pos + 3'd1;
                    if (r_pos == 3'd5) n_phase = PH_TIFF;
                end else begin
                    n_phase = (n_cnt == 16'd0) ? PH_MARK_FF : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_cnt = r_cnt - 16'd1;
                if (n_cnt == 16'd0) n_phase = PH_MARK_FF;
            end
            PH_TIFF: begin
                cmd.wr = idx17 < SegLim;
                n_cnt  = r_cnt - 16'd1;
                if (n_cnt == 16'd0) cmd.op = OP_LOOK;
            end
            default: ;
        endcase

        if (got) cmd.op = OP_RES;
        if (got || cmd.op == OP_LOOK) begin
            n_phase = PH_DONE;
            n_ans   = 1'b1;
        end
        if (i_end_of_file) begin
            // Close the file: default answer if nothing went out, then restart.
            if (cmd.op == OP_NONE && !r_ans) cmd.op = OP_RES;
            n_phase  = PH_SOI_A;
            n_pos    = 3'd0;
            n_marker = 8'h00;
            n_len    = 16'd0;
            n_cnt    = 16'd0;
            n_ans    = 1'b0;
        end
    end

    assign o_push = accept && (cmd.wr || cmd.op != OP_NONE);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SOI_A;
            r_pos    <= 3'd0;
            r_marker <= 8'h00;
            r_len    <= 16'd0;
            r_cnt    <= 16'd0;
            r_ans    <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_marker <= n_marker;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_ans    <= n_ans;
        end
    end

endmodule

// ----- design/jeof_queue.sv -----
module jeof_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jeof_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output jeof_pkg::t_cmd o_cmd
);
    import jeof_pkg::*;

    localparam int unsigned Depth = 4;
    localparam int unsigned PtrW  = $clog2(Depth);

    t_cmd              r_mem [Depth];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [PtrW:0]     r_count;
    logic              do_pop;

    assign o_full  = r_count == (PtrW+1)'(Depth);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_count <= r_count + (PtrW+1)'(i_push) - (PtrW+1)'(do_pop);
        end
    end

endmodule

// ----- design/jeof_back.sv -----
module jeof_back #(
    parameter int unsigned SEGMENT_BYTES = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  jeof_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [3:0]     o_orientation
);
    import jeof_pkg::*;

    localparam int unsigned AddrW = $clog2(SEGMENT_BYTES);

    typedef enum logic [3:0] {
        B_IDLE, B_FETCH, B_CATCH, B_BOM, B_MAGIC, B_DIR, B_COUNT,
        B_ENTRY, B_TAG, B_VALUE, B_EMIT
    } t_state;

    logic [7:0]       r_buf [SEGMENT_BYTES];
    logic [7:0]       r_rd;

    t_state           r_state, n_state, r_ret, n_ret;
    logic [AddrW-1:0] r_addr, n_addr;
    logic [1:0]       r_left, n_left;
    logic [31:0]      r_word, n_word;
    logic             r_big, n_big;
    logic [16:0]      r_size, n_size;
    logic [33:0]      r_ent, n_ent;
    logic [15:0]      r_num, n_num;
    logic [15:0]      r_idx, n_idx;
    logic [3:0]       r_res, n_res;
    logic             r_ov, n_ov;
    logic [3:0]       r_orient, n_orient;

    logic             load_ok, pop, wr_en;
    logic [15:0]      w16;
    logic [31:0]      w32;

    assign load_ok = !r_ov || !i_out_stall;
    assign w16 = r_big ? r_word[15:0] : {r_word[7:0], r_word[15:8]};
    assign w32 = r_big ? r_word
                       : {r_word[7:0], r_word[15:8], r_word[23:16], r_word[31:24]};

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_addr   = r_addr;
        n_left   = r_left;
        n_word   = r_word;
        n_big    = r_big;
        n_size   = r_size;
        n_ent    = r_ent;
        n_num    = r_num;
        n_idx    = r_idx;
        n_res    = r_res;
        n_ov     = r_ov && i_out_stall;
        n_orient = r_orient;
        pop      = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.op)
                        OP_NONE: pop = 1'b1;
                        OP_RES: begin
                            if (load_ok) begin
                                pop      = 1'b1;
                                n_ov     = 1'b1;
                                n_orient = OrientDefault;
                            end
                        end
                        OP_LOOK: begin
                            pop     = 1'b1;
                            n_size  = i_cmd.size;
                            n_addr  = '0;
                            n_left  = 2'd1;
                            n_ret   = B_BOM;
                            n_state = B_FETCH;
                        end
                        default: pop = 1'b1;
                    endcase
                end
            end
            B_FETCH: n_state = B_CATCH;
            B_CATCH: begin
                n_word = {r_word[23:0], r_rd};
                if (r_left == 2'd0) begin
                    n_state = r_ret;
                end else begin
                    n_left  = r_left - 2'd1;
                    n_addr  = r_addr + 1'b1;
                    n_state = B_FETCH;
                end
            end
            B_BOM: begin
                n_res   = OrientDefault;
                n_state = B_EMIT;
                if (r_word[15:0] == OrderBig || r_word[15:0] == OrderLittle) begin
                    n_big   = r_word[15:0] == OrderBig;
                    n_addr  = AddrW'(2);
                    n_left  = 2'd1;
                    n_ret   = B_MAGIC;
                    n_state = B_FETCH;
                end
            end
            B_MAGIC: begin
                n_res   = OrientDefault;
                n_state = B_EMIT;
                if (w16 == TiffMagic) begin
                    n_addr  = AddrW'(4);
                    n_left  = 2'd3;
                    n_ret   = B_DIR;
                    n_state = B_FETCH;
                end
            end
            B_DIR: begin
                // IFD0 offset must leave room for the entry count.
                n_res   = OrientDefault;
                n_state = B_EMIT;
                if ({1'b0, w32} + 33'd2 <= {16'd0, r_size}) begin
                    n_addr  = w32[AddrW-1:0];
                    n_left  = 2'd1;
                    n_ent   = {2'b00, w32} + 34'd2;
                    n_ret   = B_COUNT;
                    n_state = B_FETCH;
                end
            end
            B_COUNT: begin
                n_num   = w16;
                n_idx   = 16'd0;
                n_state = B_ENTRY;
            end
            B_ENTRY: begin
                n_res   = OrientDefault;
                n_state = B_EMIT;
                if (r_idx != r_num && r_ent + 34'd12 <= {17'd0, r_size}) begin
                    n_addr  = r_ent[AddrW-1:0];
                    n_left  = 2'd1;
                    n_ret   = B_TAG;
                    n_state = B_FETCH;
                end
            end
            B_TAG: begin
                if (w16 == TagOrientation) begin
                    n_addr  = AddrW'(r_ent + 34'd8);
                    n_left  = 2'd1;
                    n_ret   = B_VALUE;
                    n_state = B_FETCH;
                end else begin
                    n_idx   = r_idx + 16'd1;
                    n_ent   = r_ent + 34'd12;
                    n_state = B_ENTRY;
                end
            end
            B_VALUE: begin
                n_res   = (w16 >= 16'd1 && w16 <= 16'd8) ? w16[3:0] : OrientDefault;
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (load_ok) begin
                    n_ov     = 1'b1;
                    n_orient = r_res;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_pop = pop;
    assign wr_en = pop && i_cmd.wr;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_buf[i_cmd.idx[AddrW-1:0]] <= i_cmd.data;
        r_rd <= r_buf[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ret   <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ov    <= n_ov;
        end
        r_addr   <= n_addr;
        r_left   <= n_left;
        r_word   <= n_word;
        r_big    <= n_big;
        r_size   <= n_size;
        r_ent    <= n_ent;
        r_num    <= n_num;
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_orient <= n_orient;
    end

    assign o_out_valid   = r_ov;
    assign o_orientation = r_orient;

endmodule

// ----- design/jeof_exif_orientation_finder_top_placeholder.sv -----
module jeof_out_guard (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall,
    output logic       o_busy
);
    // Track whether a result beat is waiting at the output port.
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_valid && i_stall;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- tb/tb_jpeg_exif_orientation_finder_top.sv -----
`timescale 1ns / 100ps
module tb_jpeg_exif_orientation_finder_top;
    import jeof_pkg::*;

    localparam int NUM_BYTES_TARGET = 1750;
    localparam int NUM_FILES_MIN    = 26;
    localparam int HOLD_CYCLES      = 300;
    localparam int TAIL_CYCLES      = 200;

    // Parser phases of the predictor.
    typedef enum logic [3:0] {
        PH_SOI_A, PH_SOI_B, PH_MARK_FF, PH_MARK_ID, PH_LEN_HI,
        PH_LEN_LO, PH_HEADER, PH_SKIP, PH_TIFF, PH_DONE
    } t_phase;

    // Kinds of generated file.
    typedef enum int {
        FK_GOOD, FK_BAD_ORDER, FK_BAD_MAGIC, FK_DIR_FAR, FK_ENTRY_CUT,
        FK_NO_TAG, FK_BAD_VALUE, FK_TRUNCATED, FK_CORRUPT, FK_NOISE
    } t_file_kind;

    typedef struct {
        logic [7:0] data;
        logic       eof;
        bit         typed;
        logic [3:0] orient;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_end_of_file;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [3:0] o_orientation;

    jpeg_exif_orientation_finder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_orientation (o_orientation)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Orientation predictor: its own copy of the parser state and the
    // TIFF store, stepped once per accepted beat.
    // ------------------------------------------------------------------
    logic [7:0]  tiff_mem [0:65535];
    t_phase      ph;
    logic [2:0]  hdr_pos;
    logic [7:0]  cur_marker;
    logic [15:0] seg_len;
    logic [15:0] seg_left;
    logic        big_end;
    logic        answered;

    logic [3:0]  orient_due [$];   // orientations still owed by the block
    int          mismatches;
    int          results_seen;
    int          bytes_sent;
    int          files_sent;

    function automatic longint rd8(longint i);
        return (i < 65536) ? longint'(tiff_mem[i[15:0]]) : 0;
    endfunction

    function automatic longint rd16(longint i);
        longint a, b;
        a = rd8(i);
        b = rd8(i + 1);
        return big_end ? ((a << 8) | b) : ((b << 8) | a);
    endfunction

    function automatic longint rd32(longint i);
        longint a, b, c, d;
        a = rd8(i);
        b = rd8(i + 1);
        c = rd8(i + 2);
        d = rd8(i + 3);
        return big_end ? ((a << 24) | (b << 16) | (c << 8) | d)
                       : ((d << 24) | (c << 16) | (b << 8) | a);
    endfunction

    // Walk the stored TIFF part: byte order, magic, IFD0, orientation entry.
    function automatic logic [3:0] lookup_orientation();
        longint size, dir, pos, cnt, v;
        size = longint'(seg_len) - 8;
        if (rd8(0) == 8'h4D && rd8(1) == 8'h4D) big_end = 1'b1;
        else if (rd8(0) == 8'h49 && rd8(1) == 8'h49) big_end = 1'b0;
        else return OrientDefault;
        if (rd16(2) != longint'(TiffMagic)) return OrientDefault;
        dir = rd32(4);
        if (dir + 2 > size) return OrientDefault;
        cnt = rd16(dir);
        for (longint e = 0; e < cnt; e++) begin
            pos = dir + 2 + e * 12;
            if (pos + 12 > size) return OrientDefault;
            if (rd16(pos) == longint'(TagOrientation)) begin
                v = rd16(pos + 8);
                return (v >= 1 && v <= 8) ? v[3:0] : OrientDefault;
            end
        end
        return OrientDefault;
    endfunction

    function automatic void restart_parser();
        ph         = PH_SOI_A;
        hdr_pos    = '0;
        cur_marker = '0;
        seg_len    = '0;
        seg_left   = '0;
        big_end    = 1'b0;
        answered   = 1'b0;
    endfunction

    function automatic void predict_beat(logic [7:0] b, logic last, output bit got,
                                         output logic [3:0] res);
        logic [7:0] exif_sig [6];
        int idx;
        exif_sig = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
        got = 0;
        res = OrientDefault;
        case (ph)
            PH_SOI_A: begin
                if (b == MarkerPrefix) ph = PH_SOI_B;
                else got = 1;
            end
            PH_SOI_B: begin
                if (b == MarkerSoi) ph = PH_MARK_FF;
                else got = 1;
            end
            PH_MARK_FF: begin
                if (b == MarkerPrefix) ph = PH_MARK_ID;
                else got = 1;
            end
            PH_MARK_ID: begin
                cur_marker = b;
                if (b == MarkerSoi || b == MarkerTem || (b >= MarkerRst0 && b <= MarkerRst7))
                    ph = PH_MARK_FF;
                else if (b == MarkerSos || b == MarkerEoi)
                    got = 1;
                else
                    ph = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                seg_len = {8'h00, b};
                ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len = {seg_len[7:0], b};
                if (seg_len < 2) begin
                    got = 1;
                end else if (seg_len == 2) begin
                    ph = PH_MARK_FF;
                end else begin
                    seg_left = seg_len - 16'd2;
                    hdr_pos = '0;
                    ph = (cur_marker == MarkerApp1 && seg_len > 16) ? PH_HEADER : PH_SKIP;
                end
            end
            PH_HEADER: begin
                seg_left = seg_left - 16'd1;
                if (hdr_pos < 6 && b == exif_sig[hdr_pos]) begin
                    hdr_pos = hdr_pos + 3'd1;
                    if (hdr_pos == 6) ph = PH_TIFF;
                end else begin
                    ph = (seg_left == 0) ? PH_MARK_FF : PH_SKIP;
                end
            end
            PH_SKIP: begin
                seg_left = seg_left - 16'd1;
                if (seg_left == 0) ph = PH_MARK_FF;
            end
            PH_TIFF: begin
                idx = (int'(seg_len) - 8) - int'(seg_left);
                tiff_mem[idx[15:0]] = b;
                seg_left = seg_left - 16'd1;
                if (seg_left == 0) begin
                    res = lookup_orientation();
                    got = 1;
                end
            end
            default: ;
        endcase
        if (got) ph = PH_DONE;
        if (!got && last && !answered) begin
            res = OrientDefault;
            got = 1;
        end
        if (got) answered = 1'b1;
        if (last) restart_parser();
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    bit in_idle_on;
    bit out_idle_on;
    bit hold_req;

    task automatic send_beat(logic [7:0] b, logic last, bit typed, logic [3:0] typed_val);
        int gap;
        bit got;
        logic [3:0] res;
        gap = in_idle_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_end_of_file <= last;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (o_in_stall);
        predict_beat(b, last, got, res);
        if (got) orient_due.push_back(typed ? typed_val : res);
        bytes_sent++;
        if (last) files_sent++;
    endtask

    // ------------------------------------------------------------------
    // File generator: mostly well-formed JPEG headers with random content.
    // ------------------------------------------------------------------
    logic [7:0] file_q [$];
    logic [7:0] tiff_q [$];
    bit         gen_big;

    function automatic void put16(int v);
        if (gen_big) begin
            tiff_q.push_back(v[15:8]);
            tiff_q.push_back(v[7:0]);
        end else begin
            tiff_q.push_back(v[7:0]);
            tiff_q.push_back(v[15:8]);
        end
    endfunction

    function automatic void put32(int unsigned v);
        if (gen_big) begin
            put16(v[31:16]);
            put16(v[15:0]);
        end else begin
            put16(v[15:0]);
            put16(v[31:16]);
        end
    endfunction

    function automatic void add_segment(logic [7:0] mark, int body_len, bit exif_like);
        int len;
        len = body_len + 2;
        file_q.push_back(MarkerPrefix);
        file_q.push_back(mark);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[7:0]);
        for (int i = 0; i < body_len; i++)
            file_q.push_back(8'((exif_like && i < 4) ? "Exig" >> (8 * (3 - i)) : $urandom));
    endfunction

    function automatic logic [7:0] random_marker();
        logic [7:0] m;
        do m = 8'($urandom);
        while (m == MarkerSoi || m == MarkerTem || (m >= MarkerRst0 && m <= MarkerRst7)
               || m == MarkerSos || m == MarkerEoi || m == MarkerApp1);
        return m;
    endfunction

    function automatic void build_file(t_file_kind kind);
        int n_ent, tag_at, pad, dir, len, cut, v;
        file_q.delete();
        tiff_q.delete();
        if (kind == FK_NOISE) begin
            repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
            return;
        end
        file_q.push_back(MarkerPrefix);
        file_q.push_back(MarkerSoi);
        // leading segments that must be skipped
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
                0: begin
                    file_q.push_back(MarkerPrefix);
                    file_q.push_back(8'($urandom_range(0, 1) ? MarkerTem
                                        : MarkerRst0 + $urandom_range(0, 7)));
                end
                1: add_segment(MarkerPrefix, $urandom_range(0, 3), 0);  // fill marker
                2: add_segment(MarkerApp1, $urandom_range(15, 20), 1);  // wrong header
                3: add_segment(MarkerApp1, $urandom_range(1, 14), 0);   // too short
                default: add_segment(random_marker(), $urandom_range(0, 6), 0);
            endcase
        end
        // TIFF part
        gen_big = 1'($urandom_range(0, 1));
        if (kind == FK_BAD_ORDER) begin
            tiff_q.push_back(gen_big ? 8'h4D : 8'h49);
            tiff_q.push_back(8'($urandom_range(0, 1) ? 8'h49 : $urandom));
        end else begin
            tiff_q.push_back(gen_big ? 8'h4D : 8'h49);
            tiff_q.push_back(gen_big ? 8'h4D : 8'h49);
        end
        put16(kind == FK_BAD_MAGIC ? (42 ^ (1 << $urandom_range(0, 15))) : 42);
        pad = $urandom_range(0, 3);
        n_ent = $urandom_range(0, 4);
        tag_at = (kind == FK_NO_TAG || n_ent == 0) ? -1 : $urandom_range(0, n_ent - 1);
        dir = 8 + pad;
        if (kind == FK_DIR_FAR)
            put32($urandom_range(0, 1) ? 32'hFFFF_FFFF : 8 + pad + $urandom_range(1, 40));
        else
            put32(dir);
        repeat (pad) tiff_q.push_back(8'($urandom));
        put16(kind == FK_ENTRY_CUT ? n_ent + $urandom_range(1, 3) : n_ent);
        for (int e = 0; e < n_ent; e++) begin
            if (e == tag_at) begin
                put16(TagOrientation);
                if (kind == FK_BAD_VALUE) v = $urandom_range(0, 1) ? 0 : $urandom_range(9, 65535);
                else v = $urandom_range(1, 8);
            end else begin
                do v = $urandom_range(0, 65535); while (v == TagOrientation);
                put16(v);
                v = $urandom_range(0, 65535);
            end
            put16(3);
            put32(1);
            put16(v);
            put16($urandom_range(0, 65535));
        end
        repeat ($urandom_range(0, 2)) tiff_q.push_back(8'($urandom));
        len = tiff_q.size() + 8;
        file_q.push_back(MarkerPrefix);
        file_q.push_back(MarkerApp1);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[7:0]);
        file_q.push_back(8'h45);
        file_q.push_back(8'h78);
        file_q.push_back(8'h69);
        file_q.push_back(8'h66);
        file_q.push_back(8'h00);
        file_q.push_back(8'h00);
        foreach (tiff_q[i]) file_q.push_back(tiff_q[i]);
        // trailing bytes are ignored once the answer is out
        repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
        if (kind == FK_TRUNCATED) begin
            cut = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > cut) void'(file_q.pop_back());
        end
        if (kind == FK_CORRUPT)
            file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    endfunction

    task automatic send_file();
        foreach (file_q[i]) send_beat(file_q[i], i == file_q.size() - 1, 0, '0);
    endtask

    // Directed beats: bad starts, standalone markers, image data first,
    // short file, lost sync, bad length.
    t_row dir_rows [] = '{
        '{8'h00, 1'b0, 1, 4'd1}, '{8'h55, 1'b1, 0, 4'd0},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'h00, 1'b1, 1, 4'd1},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hD8, 1'b0, 0, 4'd0},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hD0, 1'b0, 0, 4'd0},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'h01, 1'b0, 0, 4'd0},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hD7, 1'b0, 0, 4'd0},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hDA, 1'b0, 1, 4'd1},
        '{8'h12, 1'b1, 0, 4'd0},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hD8, 1'b1, 1, 4'd1},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hD8, 1'b0, 0, 4'd0}, '{8'h3C, 1'b1, 1, 4'd1},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hD8, 1'b0, 0, 4'd0},
        '{8'hFF, 1'b0, 0, 4'd0}, '{8'hE0, 1'b0, 0, 4'd0},
        '{8'h00, 1'b0, 0, 4'd0}, '{8'h01, 1'b0, 1, 4'd1}, '{8'hFF, 1'b1, 0, 4'd0}
    };

    // ------------------------------------------------------------------
    // Receiver: random stall per result, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        i_out_stall = 1'b1;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) gap = HOLD_CYCLES;
            else gap = out_idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                hold_req = 0;
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare each result beat with the oldest owed orientation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (orient_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: orientation %0d", o_orientation);
            end else if (orient_due[0] !== o_orientation) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("orientation mismatch: expected %0d, got %0d",
                             orient_due[0], o_orientation);
                void'(orient_due.pop_front());
            end else begin
                void'(orient_due.pop_front());
            end
        end
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #(12 * 3_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        t_file_kind kind;
        int pick;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_end_of_file = 1'b0;
        in_idle_on    = 1;
        out_idle_on   = 1;
        hold_req      = 0;
        mismatches    = 0;
        results_seen  = 0;
        bytes_sent    = 0;
        files_sent    = 0;
        restart_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i].data, dir_rows[i].eof, dir_rows[i].typed, dir_rows[i].orient);

        // one file of each kind, checked against the predictor
        for (int k = FK_GOOD; k <= FK_NOISE; k++) begin
            build_file(t_file_kind'(k));
            send_file();
        end

        while (bytes_sent < NUM_BYTES_TARGET || files_sent < NUM_FILES_MIN) begin
            // alternate stretches with and without idling on each side
            if (files_sent % 8 == 0) begin
                in_idle_on  = $urandom_range(0, 3) != 0;
                out_idle_on = $urandom_range(0, 3) != 0;
            end
            // drain once completely before going on
            if (files_sent == 20) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (orient_due.size() != 0) @(posedge i_clk);
            end
            // starve the output for a long stretch while input keeps coming
            if (files_sent == 25) hold_req = 1;
            pick = $urandom_range(0, 99);
            if (pick < 50) kind = FK_GOOD;
            else if (pick < 85) kind = t_file_kind'($urandom_range(FK_BAD_ORDER, FK_BAD_VALUE));
            else kind = t_file_kind'($urandom_range(FK_TRUNCATED, FK_NOISE));
            build_file(kind);
            send_file();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (orient_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes in %0d files, %0d orientation results checked",
                 bytes_sent, files_sent, results_seen);
        $display("mix: good Exif, broken TIFF headers and offsets, truncated and noisy files");
        if (mismatches == 0 && orient_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
